// File: rtl/core/rotation_matrix_to_quaternion_macros.svh
// Assertion macros used by the top-level module.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq check failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq check failed");
`endif

// File: rtl/core/rmq_pkg.sv
// Package: the default word width and the quaternion component codes.
`timescale 1ns / 1ps
package rmq_pkg;
    localparam int unsigned WORD_BITS_DEF = 32;
    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } t_comp;
endpackage

// File: rtl/core/rmq_if.sv
// Valid/ready channel interfaces for matrices and quaternions.
`timescale 1ns / 1ps
interface rmq_mat_if #(parameter int unsigned WORD_BITS = rmq_pkg::WORD_BITS_DEF);
    logic valid;
    logic ready;
    logic signed [WORD_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if #(parameter int unsigned WORD_BITS = rmq_pkg::WORD_BITS_DEF);
    logic valid;
    logic ready;
    logic signed [WORD_BITS-1:0] quat_w, quat_x, quat_y, quat_z;
    logic clipped;
    modport source(output valid, quat_w, quat_x, quat_y, quat_z, clipped, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, clipped, output ready);
endinterface

// File: rtl/core/rmq_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt #(
    parameter int unsigned RAD_BITS = 64,
    parameter int unsigned SIDE_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [RAD_BITS-1:0]       i_rad,
    input  logic [SIDE_BITS-1:0]      i_side,
    output logic                      o_valid,
    output logic [RAD_BITS/2-1:0]     o_root,
    output logic [SIDE_BITS-1:0]      o_side
);
    localparam int unsigned N = RAD_BITS / 2;
    localparam int unsigned RW = N + 2;

    logic            r_v    [N+1];
    logic [RAD_BITS-1:0] r_rad [N+1];
    logic [RW-1:0]   r_rem  [N+1];
    logic [N-1:0]    r_root [N+1];
    logic [SIDE_BITS-1:0] r_side [N+1];

    always_comb begin
        r_v[0] = i_valid;
        r_rad[0] = i_rad;
        r_rem[0] = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_shift;
        always_comb begin
            n_shift = {r_rem[k][RW-3:0], r_rad[k][RAD_BITS-1 -: 2]};
            n_trial = {r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rad[k+1] <= {r_rad[k][RAD_BITS-3:0], 2'b00};
                r_side[k+1] <= r_side[k];
                if (n_shift >= n_trial) begin
                    r_rem[k+1] <= n_shift - n_trial;
                    r_root[k+1] <= {r_root[k][N-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_shift;
                    r_root[k+1] <= {r_root[k][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root = r_root[N];
    assign o_side = r_side[N];
endmodule

// File: rtl/core/rmq_div.sv
// Pipelined restoring divider with output saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div #(
    parameter int unsigned WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS+1:0] i_mag,
    input  logic [WORD_BITS:0]   i_den,
    input  logic                 i_neg,
    output logic [WORD_BITS-1:0] o_quot,
    output logic                 o_neg,
    output logic                 o_sat
);
    // quotient = mag * 2^(W-3) / den; saturates above 2^(W-1)-1 (2^(W-1) if negative)
    localparam int unsigned MB = WORD_BITS + 2;
    localparam int unsigned SH = WORD_BITS - 3;
    localparam int unsigned NB = MB + SH;
    localparam int unsigned QB = NB;
    localparam int unsigned RB = WORD_BITS + 2;

    logic [NB-1:0]        r_num [NB+1];
    logic [RB-1:0]        r_rem [NB+1];
    logic [QB-1:0]        r_q   [NB+1];
    logic [WORD_BITS:0]   r_den [NB+1];
    logic                 r_neg [NB+1];

    always_comb begin
        r_num[0] = {i_mag, {SH{1'b0}}};
        r_rem[0] = '0;
        r_q[0] = '0;
        r_den[0] = i_den;
        r_neg[0] = i_neg;
    end

    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [RB-1:0] n_sh;
        always_comb n_sh = {r_rem[k][RB-2:0], r_num[k][NB-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= {r_num[k][NB-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                if (n_sh >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= n_sh - {1'b0, r_den[k]};
                    r_q[k+1] <= {r_q[k][QB-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh;
                    r_q[k+1] <= {r_q[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    logic [QB-1:0] n_lim;
    always_comb begin
        n_lim = {{(QB-WORD_BITS){1'b0}}, 1'b0, {(WORD_BITS-1){1'b1}}}
                + {{(QB-1){1'b0}}, r_neg[NB]};
        o_sat = r_q[NB] > n_lim;
        o_quot = o_sat ? n_lim[WORD_BITS-1:0] : r_q[NB][WORD_BITS-1:0];
        o_neg = r_neg[NB];
    end
endmodule

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Top level: matrix to quaternion conversion pipeline.
`timescale 1ns / 1ps
// Streams one 3x3 rotation matrix (signed Q2.FRAC, FRAC = WORD_BITS-2) per
// cycle while the output is not stalled and returns the quaternion w, x, y,
// z in the same format plus a clipped flag. Throughput is one beat per cycle
// unless the output stalls. The pipeline is built around the bit-per-stage
// square root (WORD_BITS+2 stages of root bits) followed by the bit-per-stage
// divider (2*WORD_BITS-1 stages). A stall on the output freezes the whole
// pipeline; an output register holds the finished beat. The trace branch is
// used when m00+m11+m22 > 0, else the largest diagonal entry picks the pivot.
// A non-positive root argument or a saturated component sets clipped.
module rotation_matrix_to_quaternion #(
    parameter int unsigned WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;
    `include "rotation_matrix_to_quaternion_macros.svh"

    localparam int unsigned W = WORD_BITS;
    localparam int unsigned FRAC = W - 2;
    localparam int unsigned AB = W + 3;            // argument / pair width
    localparam int unsigned RAD = 2 * (W + 2);      // radicand width (even)
    localparam int unsigned SIDE = 1 + 2 + 4 + 4 * AB; // bad, piv, spare zero bits, pairs
    localparam int unsigned DIVL = 2 * W - 1;

    // pipeline advances when output register is free or being read
    logic n_en;
    logic r_ov;
    assign n_en = !r_ov || o_quat.ready;
    assign i_mat.ready = n_en;

    // stage 1: sums
    logic signed [AB-1:0] n_e [9];
    always_comb begin
        n_e[0] = AB'(i_mat.m00); n_e[1] = AB'(i_mat.m01); n_e[2] = AB'(i_mat.m02);
        n_e[3] = AB'(i_mat.m10); n_e[4] = AB'(i_mat.m11); n_e[5] = AB'(i_mat.m12);
        n_e[6] = AB'(i_mat.m20); n_e[7] = AB'(i_mat.m21); n_e[8] = AB'(i_mat.m22);
    end

    logic r_v1;
    logic signed [AB-1:0] r_tr, r_a0, r_a1, r_a2;
    logic signed [AB-1:0] r_d12, r_d20, r_d01, r_s01, r_s02, r_s12;
    logic r_g01, r_g02, r_g12;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (n_en) r_v1 <= i_mat.valid;
        if (n_en) begin
            r_tr  <= n_e[0] + n_e[4] + n_e[8];
            r_a0  <= n_e[0] - n_e[4] - n_e[8];
            r_a1  <= n_e[4] - n_e[0] - n_e[8];
            r_a2  <= n_e[8] - n_e[0] - n_e[4];
            r_d12 <= n_e[7] - n_e[5];
            r_d20 <= n_e[2] - n_e[6];
            r_d01 <= n_e[3] - n_e[1];
            r_s01 <= n_e[1] + n_e[3];
            r_s02 <= n_e[2] + n_e[6];
            r_s12 <= n_e[5] + n_e[7];
            r_g01 <= n_e[0] > n_e[4];
            r_g02 <= n_e[0] > n_e[8];
            r_g12 <= n_e[4] > n_e[8];
        end
    end

    // stage 2: branch select
    localparam logic signed [AB-1:0] ONE = AB'(1) <<< FRAC;
    logic [1:0] n_piv;
    logic signed [AB-1:0] n_arg;
    logic signed [AB-1:0] n_p [4];
    always_comb begin
        n_p[0] = '0; n_p[1] = '0; n_p[2] = '0; n_p[3] = '0;
        if (r_tr > 0) begin
            n_piv = COMP_W; n_arg = ONE + r_tr;
            n_p[1] = r_d12; n_p[2] = r_d20; n_p[3] = r_d01;
        end else if (r_g01 && r_g02) begin
            n_piv = COMP_X; n_arg = ONE + r_a0;
            n_p[2] = r_s01; n_p[3] = r_s02; n_p[0] = r_d12;
        end else if (r_g12) begin
            n_piv = COMP_Y; n_arg = ONE + r_a1;
            n_p[1] = r_s01; n_p[3] = r_s12; n_p[0] = r_d20;
        end else begin
            n_piv = COMP_Z; n_arg = ONE + r_a2;
            n_p[1] = r_s02; n_p[2] = r_s12; n_p[0] = r_d01;
        end
    end

    logic r_v2, r_bad2;
    logic [1:0] r_piv2;
    logic [RAD-1:0] r_rad2;
    logic signed [AB-1:0] r_p2 [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (n_en) r_v2 <= r_v1;
        if (n_en) begin
            r_piv2 <= n_piv;
            r_bad2 <= n_arg <= 0;
            r_rad2 <= {{(RAD-AB-FRAC){1'b0}}, (n_arg > 0) ? n_arg : '0, {FRAC{1'b0}}};
            for (int j = 0; j < 4; j++) r_p2[j] <= n_p[j];
        end
    end

    // square root, side data rides along
    logic [SIDE-1:0] n_side_in, n_side_out;
    logic n_sq_v;
    logic [RAD/2-1:0] n_root;
    assign n_side_in = {r_bad2, r_piv2, 4'b0, r_p2[0], r_p2[1], r_p2[2], r_p2[3]};
    rmq_sqrt #(.RAD_BITS(RAD), .SIDE_BITS(SIDE)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en), .i_valid(r_v2),
        .i_rad(r_rad2), .i_side(n_side_in),
        .o_valid(n_sq_v), .o_root(n_root), .o_side(n_side_out)
    );

    logic n_bad3;
    logic [1:0] n_piv3;
    logic signed [AB-1:0] n_p3 [4];
    always_comb begin
        n_bad3 = n_side_out[SIDE-1];
        n_piv3 = n_side_out[SIDE-2 -: 2];
        for (int j = 0; j < 4; j++) n_p3[j] = n_side_out[(3-j)*AB +: AB];
    end

    // stage 3: register root, magnitudes, half
    logic r_v3, r_bad3;
    logic [1:0] r_piv3;
    logic [W:0] r_s3;
    logic [W+1:0] r_mag3 [4];
    logic [3:0] r_neg3, r_nz3;
    logic [W-1:0] r_half3;
    logic r_hsat3;
    logic [RAD/2-2:0] n_half;
    assign n_half = n_root[RAD/2-1:1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (n_en) r_v3 <= n_sq_v;
        if (n_en) begin
            r_bad3 <= n_bad3;
            r_piv3 <= n_piv3;
            r_s3 <= n_bad3 ? (W+1)'(1) : n_root[W:0];
            r_hsat3 <= n_half > (RAD/2-1)'({(W-1){1'b1}});
            r_half3 <= (n_half > (RAD/2-1)'({(W-1){1'b1}})) ? {1'b0, {(W-1){1'b1}}}
                                                         : n_half[W-1:0];
            for (int j = 0; j < 4; j++) begin
                r_neg3[j] <= n_p3[j][AB-1];
                r_nz3[j] <= n_p3[j] != 0;
                r_mag3[j] <= n_p3[j][AB-1] ? (W+2)'(-n_p3[j]) : (W+2)'(n_p3[j]);
            end
        end
    end

    // four dividers; pivot/ctrl delayed alongside
    logic [W-1:0] n_q [4];
    logic [3:0] n_qn, n_qs;
    for (genvar j = 0; j < 4; j++) begin : g_div
        rmq_div #(.WORD_BITS(W)) u_div (
            .i_clk(i_clk), .i_en(n_en),
            .i_mag(r_mag3[j]), .i_den(r_s3), .i_neg(r_neg3[j]),
            .o_quot(n_q[j]), .o_neg(n_qn[j]), .o_sat(n_qs[j])
        );
    end

    localparam int unsigned CB = 1 + 1 + 2 + 4 + W + 1;
    logic [CB-1:0] r_dl [DIVL+1];
    always_comb r_dl[0] = {r_v3, r_bad3, r_piv3, r_nz3, r_half3, r_hsat3};
    for (genvar k = 0; k < DIVL; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dl[k+1][CB-1] <= 1'b0;
            else if (n_en) r_dl[k+1][CB-1] <= r_dl[k][CB-1];
            if (n_en) r_dl[k+1][CB-2:0] <= r_dl[k][CB-2:0];
        end
    end

    logic n_fv, n_fbad, n_fhs;
    logic [1:0] n_fpiv;
    logic [3:0] n_fnz;
    logic [W-1:0] n_fhalf;
    assign {n_fv, n_fbad, n_fpiv, n_fnz, n_fhalf, n_fhs} = r_dl[DIVL];

    // final assembly
    logic [W-1:0] n_res [4];
    logic n_clip;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAXN = {1'b1, {(W-1){1'b0}}};
    always_comb begin
        n_clip = n_fbad || (!n_fbad && n_fhs);
        for (int j = 0; j < 4; j++) begin
            if (n_fpiv == 2'(j)) begin
                n_res[j] = n_fbad ? '0 : n_fhalf;
            end else if (n_fbad) begin
                n_res[j] = !n_fnz[j] ? '0 : (n_qn[j] ? MAXN : MAXP);
            end else begin
                n_res[j] = n_qn[j] ? -n_q[j] : n_q[j];
                if (n_qs[j]) n_clip = 1'b1;
            end
        end
    end

    logic [W-1:0] r_o [4];
    logic r_oc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (n_en) r_ov <= n_fv;
        if (n_en) begin
            for (int j = 0; j < 4; j++) r_o[j] <= n_res[j];
            r_oc <= n_clip;
        end
    end

    assign o_quat.valid = r_ov;
    assign o_quat.quat_w = r_o[0];
    assign o_quat.quat_x = r_o[1];
    assign o_quat.quat_y = r_o[2];
    assign o_quat.quat_z = r_o[3];
    assign o_quat.clipped = r_oc;

    `RMQ_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !r_ov, i_mat.ready)
    `RMQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !o_quat.ready, r_ov && $stable(r_o[0]))
    `RMQ_ASSERT_IMP(a_bad_clip, i_clk, i_rst_n, n_fv && n_fbad, n_clip)
endmodule
